@@ design/ssw_pkg.sv @@
// ----------------------------------------------------------------------------
// ssw_pkg
// Shared widths and codes for the skid-steer wheel mixer.
// ----------------------------------------------------------------------------
package ssw_pkg;

    localparam int LX_W       = 13;
    localparam int AZ_W       = 14;
    localparam int DUTY_W     = 10;
    localparam int DIR_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    localparam logic [DIR_W-1:0] DIR_OFF = 2'd0;
    localparam logic [DIR_W-1:0] DIR_FWD = 2'd1;
    localparam logic [DIR_W-1:0] DIR_REV = 2'd2;

    localparam logic [DUTY_W-1:0] DUTY_CAP = 10'd990;

    // 60 / (2*pi) in Q16, rounded
    localparam logic [19:0] RPM_K = 20'd625823;

    // ceil(2^48 / 125): X*16/125 becomes (X * BASE_RECIP) >> 44, exact for X below 2^37
    localparam logic [41:0] BASE_RECIP = 42'd2251799813686;

endpackage

@@ design/ssw_if.sv @@
// ----------------------------------------------------------------------------
// ssw_if
// Command and drive channels of the skid-steer wheel mixer.
// ----------------------------------------------------------------------------
interface ssw_cmd_if import ssw_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic signed [LX_W-1:0] linear_x;
    logic signed [AZ_W-1:0] angular_z;

    modport source (output valid, output linear_x, output angular_z, input ready);
    modport sink   (input valid, input linear_x, input angular_z, output ready);
endinterface

interface ssw_drv_if import ssw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] front_left_duty;
    logic [DIR_W-1:0]  front_left_dir;
    logic [DUTY_W-1:0] front_right_duty;
    logic [DIR_W-1:0]  front_right_dir;
    logic [DUTY_W-1:0] rear_left_duty;
    logic [DIR_W-1:0]  rear_left_dir;
    logic [DUTY_W-1:0] rear_right_duty;
    logic [DIR_W-1:0]  rear_right_dir;

    modport source (
        output valid, input ready,
        output front_left_duty, output front_left_dir,
        output front_right_duty, output front_right_dir,
        output rear_left_duty, output rear_left_dir,
        output rear_right_duty, output rear_right_dir
    );
    modport sink (
        input valid, output ready,
        input front_left_duty, input front_left_dir,
        input front_right_duty, input front_right_dir,
        input rear_left_duty, input rear_left_dir,
        input rear_right_duty, input rear_right_dir
    );
endinterface

@@ design/skid_steer_wheel_mixer.sv @@
// ----------------------------------------------------------------------------
// skid_steer_wheel_mixer
// Body velocity command to four wheel duty/direction commands.
// ----------------------------------------------------------------------------
//   channel  | dir | word                                 | handshake
//   i_cmd    | in  | linear_x, angular_z                  | valid/ready
//   o_drv    | out | duty + dir for FL, FR, RL, RR        | valid/ready
//   i_cfg_*  | in  | register index, data                 | write enable only
//
// One word per cycle while o_drv is not stalled; accepted words reach o_drv.valid
// through the chain of one-bit-per-stage dividers (34 arc, 52 rpm, 10 duty).
// Every stage advances together whenever the output register is empty or taken;
// a stalled output holds the whole pipeline and i_cmd.ready drops.
// Reset loads the configuration defaults and clears every valid bit.
// ----------------------------------------------------------------------------
module skid_steer_wheel_mixer
    import ssw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ssw_cmd_if.sink               i_cmd,
    ssw_drv_if.source             o_drv,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH     = 3'd0,
        CFG_WHEELBASE = 3'd1,
        CFG_RADIUS    = 3'd2,
        CFG_MAX_RPM   = 3'd3,
        CFG_GAIN      = 3'd4,
        CFG_MIN_SPEED = 3'd5,
        CFG_STOP_THR  = 3'd6
    } t_cfg_idx;

    // ---------------- configuration ----------------
    logic [10:0] r_wid, r_wb;
    logic [8:0]  r_rad;
    logic [13:0] r_mrpm;
    logic [11:0] r_gain;
    logic [9:0]  r_min, r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wid  <= 11'd250;
            r_wb   <= 11'd203;
            r_rad  <= 9'd50;
            r_mrpm <= 14'd200;
            r_gain <= 12'd768;
            r_min  <= 10'd150;
            r_thr  <= 10'd10;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_WIDTH:     r_wid  <= i_cfg_data[10:0];
                CFG_WHEELBASE: r_wb   <= i_cfg_data[10:0];
                CFG_RADIUS:    r_rad  <= i_cfg_data[8:0];
                CFG_MAX_RPM:   r_mrpm <= i_cfg_data[13:0];
                CFG_GAIN:      r_gain <= i_cfg_data[11:0];
                CFG_MIN_SPEED: r_min  <= i_cfg_data[9:0];
                CFG_STOP_THR:  r_thr  <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // zero is taken as one
    logic [10:0] w_wid;
    logic [8:0]  w_rad;
    logic [13:0] w_mrpm;
    assign w_wid  = (r_wid == 11'd0) ? 11'd1 : r_wid;
    assign w_rad  = (r_rad == 9'd0) ? 9'd1 : r_rad;
    assign w_mrpm = (r_mrpm == 14'd0) ? 14'd1 : r_mrpm;

    // ---------------- flow control ----------------
    logic r_out_vld;
    logic w_adv;
    assign w_adv       = !r_out_vld || o_drv.ready;
    assign i_cmd.ready = w_adv;

    // ---------------- stage 0: capture ----------------
    logic                   r0_vld;
    logic signed [LX_W-1:0] r0_v;
    logic [AZ_W-1:0]        r0_aw;
    logic                   r0_wneg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (w_adv) begin
            r0_vld <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r0_v    <= i_cmd.linear_x;
            r0_wneg <= i_cmd.angular_z[AZ_W-1];
            r0_aw   <= i_cmd.angular_z[AZ_W-1] ? (~i_cmd.angular_z + 1'b1)
                                                : i_cmd.angular_z;
        end
    end

    // ---------------- stages 1-2: products ----------------
    logic                   r1_vld, r2_vld;
    logic signed [LX_W-1:0] r1_v, r2_v;
    logic                   r1_wneg, r2_wneg;
    logic [24:0]            r1_pw, r1_wbaw, r2_wbaw;
    logic [36:0]            r2_pg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else if (w_adv) begin
            r1_vld <= r0_vld;
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_v    <= r0_v;
            r1_wneg <= r0_wneg;
            r1_pw   <= {14'd0, w_wid} * {11'd0, r0_aw};
            r1_wbaw <= {14'd0, r_wb} * {11'd0, r0_aw};
            r2_v    <= r1_v;
            r2_wneg <= r1_wneg;
            r2_wbaw <= r1_wbaw;
            r2_pg   <= {12'd0, r1_pw} * {25'd0, r_gain};
        end
    end

    // ---------------- turn base by reciprocal ----------------
    // |b| = W*|w|*gain*16 / 125 = (X * BASE_RECIP) >> 44, four partial products
    logic                   r2a_vld, r2b_vld;
    logic signed [LX_W-1:0] r2a_v, r2b_v;
    logic                   r2a_wneg, r2b_wneg;
    logic [24:0]            r2a_wbaw, r2b_wbaw;
    logic [38:0]            r2a_phh, r2a_phl;
    logic [39:0]            r2a_plh, r2a_pll;
    logic [33:0]            r2b_bmag;
    logic [79:0]            w_bsum;

    assign w_bsum = {1'b0, r2a_phh, 40'd0} + {22'd0, r2a_phl, 19'd0}
                  + {19'd0, r2a_plh, 21'd0} + {40'd0, r2a_pll};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2a_vld <= 1'b0;
            r2b_vld <= 1'b0;
        end else if (w_adv) begin
            r2a_vld <= r2_vld;
            r2b_vld <= r2a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2a_v    <= r2_v;
            r2a_wneg <= r2_wneg;
            r2a_wbaw <= r2_wbaw;
            r2a_phh  <= {21'd0, r2_pg[36:19]} * {18'd0, BASE_RECIP[41:21]};
            r2a_phl  <= {21'd0, r2_pg[36:19]} * {18'd0, BASE_RECIP[20:0]};
            r2a_plh  <= {21'd0, r2_pg[18:0]} * {19'd0, BASE_RECIP[41:21]};
            r2a_pll  <= {21'd0, r2_pg[18:0]} * {19'd0, BASE_RECIP[20:0]};
            r2b_v    <= r2a_v;
            r2b_wneg <= r2a_wneg;
            r2b_wbaw <= r2a_wbaw;
            r2b_bmag <= w_bsum[77:44];
        end
    end

    // ---------------- arc term divider ----------------
    logic                   w_tvld;
    logic [33:0]            w_t, w_bmag;
    logic signed [LX_W-1:0] w_tv;
    logic                   w_bwneg;
    logic [21:0]            w_tden;
    logic [LX_W+34:0]       w_tside;
    assign w_tden = {11'd0, w_wid} * 22'd2000;

    // t = wb*|w|*2^16 / (2000*W); carry v, sign of w and |b| alongside
    ssw_div #(.NW(41), .DW(22), .QW(34), .SW(LX_W+35)) u_div_arc (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_adv),
        .i_valid(r2b_vld),
        .i_num  ({r2b_wbaw, 16'd0}),
        .i_den  (w_tden),
        .i_side ({r2b_v, r2b_wneg, r2b_bmag}),
        .o_valid(w_tvld),
        .o_quot (w_t),
        .o_side (w_tside)
    );

    assign w_tv    = w_tside[LX_W+34:35];
    assign w_bwneg = w_tside[34];
    assign w_bmag  = w_tside[33:0];

    // ---------------- stages 3-5: turn terms ----------------
    logic                   r3_vld, r4_vld, r5_vld;
    logic signed [LX_W-1:0] r3_v, r4_v, r5_v;
    logic                   r3_wneg, r4_wneg;
    logic [33:0]            r3_bmag;
    logic [30:0]            r3_gf, r3_grm;
    logic                   r3_grneg, r4_grneg;
    logic [47:0]            r4_pfh, r4_pfl, r4_prh, r4_prl;
    logic [46:0]            r5_tfm, r5_trm;
    logic                   r5_tfneg, r5_trneg;
    logic [64:0]            w_prod_f, w_prod_r;

    assign w_prod_f = {r4_pfh, 17'd0} + {17'd0, r4_pfl};
    assign w_prod_r = {r4_prh, 17'd0} + {17'd0, r4_prl};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else if (w_adv) begin
            r3_vld <= w_tvld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_v     <= w_tv;
            r3_wneg  <= w_bwneg;
            r3_bmag  <= w_bmag;
            r3_gf    <= 31'd65536 + w_t[30:0];
            // rear gain goes negative once the arc term passes one
            r3_grneg <= (w_t > 34'd65536);
            r3_grm   <= (w_t > 34'd65536) ? (w_t[30:0] - 31'd65536)
                                          : (31'd65536 - w_t[30:0]);
            r4_v     <= r3_v;
            r4_wneg  <= r3_wneg;
            r4_grneg <= r3_grneg;
            r4_pfh   <= {31'd0, r3_bmag[33:17]} * {17'd0, r3_gf};
            r4_pfl   <= {31'd0, r3_bmag[16:0]} * {17'd0, r3_gf};
            r4_prh   <= {31'd0, r3_bmag[33:17]} * {17'd0, r3_grm};
            r4_prl   <= {31'd0, r3_bmag[16:0]} * {17'd0, r3_grm};
            r5_v     <= r4_v;
            r5_tfm   <= w_prod_f[62:16];
            r5_trm   <= w_prod_r[62:16];
            r5_tfneg <= r4_wneg;
            r5_trneg <= r4_wneg ^ r4_grneg;
        end
    end

    // ---------------- stages 6-9: wheel speeds to scaled rpm numerator ----------------
    logic signed [48:0] w_vq, w_tf, w_tr;
    assign w_vq = {{20{r5_v[LX_W-1]}}, r5_v, 16'd0};
    assign w_tf = r5_tfneg ? -$signed({2'b00, r5_tfm}) : $signed({2'b00, r5_tfm});
    assign w_tr = r5_trneg ? -$signed({2'b00, r5_trm}) : $signed({2'b00, r5_trm});

    logic               r6_vld, r7_vld, r8_vld, r9_vld;
    logic signed [48:0] r6_vel [4];
    logic [47:0]        r7_mag [4];
    logic [DIR_W-1:0]   r7_dir [4], r8_dir [4], r9_dir [4];
    logic [43:0]        r8_ph  [4], r8_pl [4];
    logic [51:0]        r9_x   [4];
    logic [47:0]        w_minq, w_thrq;
    assign w_minq = {22'd0, r_min, 16'd0};
    assign w_thrq = {22'd0, r_thr, 16'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
            r7_vld <= 1'b0;
            r8_vld <= 1'b0;
            r9_vld <= 1'b0;
        end else if (w_adv) begin
            r6_vld <= r5_vld;
            r7_vld <= r6_vld;
            r8_vld <= r7_vld;
            r9_vld <= r8_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [48:0] v_abs;
        logic [68:0] v_sum;
        if (w_adv) begin
            r6_vel[0] <= w_vq - w_tf;
            r6_vel[1] <= w_vq + w_tf;
            r6_vel[2] <= w_vq - w_tr;
            r6_vel[3] <= w_vq + w_tr;
            for (int i = 0; i < 4; i++) begin
                v_abs = r6_vel[i][48] ? 49'(-r6_vel[i]) : 49'(r6_vel[i]);
                // lift speeds above the stop threshold but below the minimum up to the minimum
                if (v_abs[47:0] > w_thrq && v_abs[47:0] < w_minq) begin
                    r7_mag[i] <= w_minq;
                end else begin
                    r7_mag[i] <= v_abs[47:0];
                end
                if (r6_vel[i] == 49'sd0) begin
                    r7_dir[i] <= DIR_OFF;
                end else if (r6_vel[i][48]) begin
                    r7_dir[i] <= DIR_REV;
                end else begin
                    r7_dir[i] <= DIR_FWD;
                end
                r8_ph[i]  <= {20'd0, r7_mag[i][47:24]} * {24'd0, RPM_K};
                r8_pl[i]  <= {20'd0, r7_mag[i][23:0]} * {24'd0, RPM_K};
                r8_dir[i] <= r7_dir[i];
                v_sum     = {1'b0, r8_ph[i], 24'd0} + {25'd0, r8_pl[i]};
                r9_x[i]   <= v_sum[67:16];
                r9_dir[i] <= r8_dir[i];
            end
        end
    end

    // ---------------- rpm dividers ----------------
    logic [51:0]      w_rpm  [4];
    logic [DIR_W-1:0] w_rdir [4];
    logic             w_rvld [4];

    for (genvar g = 0; g < 4; g++) begin : g_rpm
        ssw_div #(.NW(52), .DW(9), .QW(52), .SW(DIR_W)) u_div_rpm (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_adv),
            .i_valid(r9_vld),
            .i_num  (r9_x[g]),
            .i_den  (w_rad),
            .i_side (r9_dir[g]),
            .o_valid(w_rvld[g]),
            .o_quot (w_rpm[g]),
            .o_side (w_rdir[g])
        );
    end

    // ---------------- stages 10-12: common scale ----------------
    logic             r10_vld, r11_vld, r12_vld;
    logic [51:0]      r10_rpm [4], r11_rpm [4];
    logic [DIR_W-1:0] r10_dir [4], r11_dir [4], r12_dir [4];
    logic [51:0]      r10_m01, r10_m23, r11_top, r12_den;
    logic [61:0]      r12_num [4];
    logic [51:0]      w_rfull;
    assign w_rfull = {22'd0, w_mrpm, 16'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_vld <= 1'b0;
            r11_vld <= 1'b0;
            r12_vld <= 1'b0;
        end else if (w_adv) begin
            r10_vld <= w_rvld[0];
            r11_vld <= r10_vld;
            r12_vld <= r11_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r10_m01 <= (w_rpm[0] > w_rpm[1]) ? w_rpm[0] : w_rpm[1];
            r10_m23 <= (w_rpm[2] > w_rpm[3]) ? w_rpm[2] : w_rpm[3];
            r11_top <= (r10_m01 > r10_m23) ? r10_m01 : r10_m23;
            r12_den <= (r11_top > w_rfull) ? r11_top : w_rfull;
            for (int i = 0; i < 4; i++) begin
                r10_rpm[i] <= w_rpm[i];
                r10_dir[i] <= w_rdir[i];
                r11_rpm[i] <= r10_rpm[i];
                r11_dir[i] <= r10_dir[i];
                r12_num[i] <= {10'd0, r11_rpm[i]} * 62'd1000;
                r12_dir[i] <= r11_dir[i];
            end
        end
    end

    // ---------------- duty dividers ----------------
    logic [DUTY_W-1:0] w_q    [4];
    logic [DIR_W-1:0]  w_ddir [4];
    logic              w_dvld [4];

    for (genvar g = 0; g < 4; g++) begin : g_duty
        ssw_div #(.NW(62), .DW(52), .QW(DUTY_W), .SW(DIR_W)) u_div_duty (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_adv),
            .i_valid(r12_vld),
            .i_num  (r12_num[g]),
            .i_den  (r12_den),
            .i_side (r12_dir[g]),
            .o_valid(w_dvld[g]),
            .o_quot (w_q[g]),
            .o_side (w_ddir[g])
        );
    end

    // ---------------- output register ----------------
    logic [DUTY_W-1:0] r_duty [4];
    logic [DIR_W-1:0]  r_dir  [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= w_dvld[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 4; i++) begin
                r_duty[i] <= (w_q[i] > DUTY_CAP) ? DUTY_CAP : w_q[i];
                r_dir[i]  <= w_ddir[i];
            end
        end
    end

    assign o_drv.valid            = r_out_vld;
    assign o_drv.front_left_duty  = r_duty[0];
    assign o_drv.front_left_dir   = r_dir[0];
    assign o_drv.front_right_duty = r_duty[1];
    assign o_drv.front_right_dir  = r_dir[1];
    assign o_drv.rear_left_duty   = r_duty[2];
    assign o_drv.rear_left_dir    = r_dir[2];
    assign o_drv.rear_right_duty  = r_duty[3];
    assign o_drv.rear_right_dir   = r_dir[3];

`ifndef SYNTHESIS
    a_lanes_lockstep : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rvld[0] == w_rvld[1] && w_rvld[0] == w_rvld[2] && w_rvld[0] == w_rvld[3] &&
        w_dvld[0] == w_dvld[1] && w_dvld[0] == w_dvld[2] && w_dvld[0] == w_dvld[3])
        else $error("wheel divider lanes out of step");

    a_accept_enters : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |=> r0_vld)
        else $error("accepted word missing from first stage");

    a_off_zero_duty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> ((r_dir[0] != DIR_OFF || r_duty[0] == '0) &&
                       (r_dir[1] != DIR_OFF || r_duty[1] == '0) &&
                       (r_dir[2] != DIR_OFF || r_duty[2] == '0) &&
                       (r_dir[3] != DIR_OFF || r_duty[3] == '0)))
        else $error("wheel off with nonzero duty");
`endif

endmodule

@@ design/ssw_div.sv @@
// ----------------------------------------------------------------------------
// ssw_div
// Pipelined restoring divider, one quotient bit per stage.
// Expects i_num < i_den * 2**QW; quotient is floor(i_num / i_den).
// ----------------------------------------------------------------------------
module ssw_div #(
    parameter int NW = 16,
    parameter int DW = 8,
    parameter int QW = 8,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_quot,
    output logic [SW-1:0] o_side
);

    localparam int AW = DW + QW;

    // remainder in the top DW bits, dividend bits / quotient bits below
    logic [AW-1:0] r_acc  [QW];
    logic [DW-1:0] r_den  [QW];
    logic [SW-1:0] r_side [QW];
    logic          r_vld  [QW];

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [AW-1:0] w_acc;
        logic [DW-1:0] w_den;
        logic [SW-1:0] w_side;
        logic          w_vld;
        logic [DW:0]   w_trial;
        logic [DW:0]   w_diff;
        logic          w_ge;
        logic [AW-1:0] n_acc;

        if (k == 0) begin : g_head
            assign w_acc  = AW'(i_num);
            assign w_den  = i_den;
            assign w_side = i_side;
            assign w_vld  = i_valid;
        end else begin : g_body
            assign w_acc  = r_acc[k-1];
            assign w_den  = r_den[k-1];
            assign w_side = r_side[k-1];
            assign w_vld  = r_vld[k-1];
        end

        assign w_trial = w_acc[AW-1:QW-1];
        assign w_diff  = w_trial - {1'b0, w_den};
        assign w_ge    = (w_trial >= {1'b0, w_den});
        assign n_acc   = {(w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0]), w_acc[QW-2:0], w_ge};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_acc[k]  <= n_acc;
                r_den[k]  <= w_den;
                r_side[k] <= w_side;
            end
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_quot  = r_acc[QW-1][QW-1:0];
    assign o_side  = r_side[QW-1];

endmodule
